// ----- hdl/jsu_pkg.sv -----
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, status codes and helper functions for the JSON string
// unescaper: hex digit decode, result group builders and UTF-8 encoding of one code point.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

    typedef enum logic [3:0] {
        ST_BYTE       = 4'd0,
        ST_CLOSED     = 4'd1,
        ST_UNTERM     = 4'd2,
        ST_END_ESC    = 4'd3,
        ST_SHORT_U    = 4'd4,
        ST_BAD_HEX    = 4'd5,
        ST_NO_LOW     = 4'd6,
        ST_BAD_HEX_LO = 4'd7,
        ST_BAD_LOW    = 4'd8,
        ST_BAD_ESC    = 4'd9,
        ST_CTRL       = 4'd10
    } status_t;

    localparam logic [3:0] ST_MAX = 4'd10;

    // one group of results caused by a single input beat
    typedef struct packed {
        logic [3:0][7:0] data;
        logic [1:0]      last_idx;
        status_t         status;
    } burst_t;

    // bit 4 set: not a hex digit
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c inside {[8'h30:8'h39]}) begin
            v = {1'b0, c[3:0]};
        end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            v = {1'b0, c[3:0] + 4'd9};
        end
        return v;
    endfunction

    function automatic burst_t make_status(input status_t st);
        burst_t b;
        b          = '0;
        b.status   = st;
        return b;
    endfunction

    function automatic burst_t make_byte(input logic [7:0] val);
        burst_t b;
        b         = '0;
        b.data[0] = val;
        b.status  = ST_BYTE;
        return b;
    endfunction

    function automatic burst_t utf8_encode(input logic [20:0] cp);
        burst_t b;
        b        = '0;
        b.status = ST_BYTE;
        if (cp < 21'h80) begin
            b.data[0]  = cp[7:0];
            b.last_idx = 2'd0;
        end else if (cp < 21'h800) begin
            b.data[0]  = 8'hC0 | {3'b0, cp[10:6]};
            b.data[1]  = 8'h80 | {2'b0, cp[5:0]};
            b.last_idx = 2'd1;
        end else if (cp < 21'h10000) begin
            b.data[0]  = 8'hE0 | {4'b0, cp[15:12]};
            b.data[1]  = 8'h80 | {2'b0, cp[11:6]};
            b.data[2]  = 8'h80 | {2'b0, cp[5:0]};
            b.last_idx = 2'd2;
        end else begin
            b.data[0]  = 8'hF0 | {5'b0, cp[20:18]};
            b.data[1]  = 8'h80 | {2'b0, cp[17:12]};
            b.data[2]  = 8'h80 | {2'b0, cp[11:6]};
            b.data[3]  = 8'h80 | {2'b0, cp[5:0]};
            b.last_idx = 2'd3;
        end
        return b;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/jsu_decode.sv -----
// ----------------------------------------------------------------------------
// jsu_decode
// Escape state machine: holds the parse state and turns each accepted beat
// into zero or one result group for the output serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_decode (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            accept,
    input  wire logic [7:0]      byte_in,
    input  wire logic            source_end,
    output jsu_pkg::burst_t      burst,
    output logic                 emit
);

    typedef enum logic [2:0] {
        M_TEXT,
        M_ESC,
        M_HEX_HI,
        M_LO_BSL,
        M_LO_U,
        M_HEX_LO
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic [15:0] first_reg, first_next;
    logic [15:0] second_reg, second_next;
    logic [1:0]  count_reg, count_next;
    logic        bad_reg, bad_next;

    logic [4:0]  dval;
    logic [3:0]  nib;
    logic [15:0] unit_hi;
    logic [15:0] unit_lo;

    assign dval    = jsu_pkg::hex_val(byte_in);
    assign nib     = dval[4] ? 4'd0 : dval[3:0];
    assign unit_hi = {first_reg[11:0], nib};
    assign unit_lo = {second_reg[11:0], nib};

    always_comb begin
        mode_next   = mode_reg;
        first_next  = first_reg;
        second_next = second_reg;
        count_next  = count_reg;
        bad_next    = bad_reg;
        emit        = 1'b0;
        burst       = jsu_pkg::make_status(jsu_pkg::ST_BYTE);
        case (mode_reg)
            M_ESC: begin
                emit      = 1'b1;
                mode_next = M_TEXT;
                if (source_end) begin
                    burst = jsu_pkg::make_status(jsu_pkg::ST_END_ESC);
                end else begin
                    case (byte_in)
                        8'h22, 8'h5C, 8'h2F: burst = jsu_pkg::make_byte(byte_in);
                        8'h62: burst = jsu_pkg::make_byte(8'h08);
                        8'h66: burst = jsu_pkg::make_byte(8'h0C);
                        8'h6E: burst = jsu_pkg::make_byte(8'h0A);
                        8'h72: burst = jsu_pkg::make_byte(8'h0D);
                        8'h74: burst = jsu_pkg::make_byte(8'h09);
                        8'h75: begin
                            emit       = 1'b0;
                            mode_next  = M_HEX_HI;
                            first_next = '0;
                            count_next = '0;
                            bad_next   = 1'b0;
                        end
                        default: burst = jsu_pkg::make_status(jsu_pkg::ST_BAD_ESC);
                    endcase
                end
            end
            M_HEX_HI: begin
                if (source_end) begin
                    emit      = 1'b1;
                    mode_next = M_TEXT;
                    burst     = jsu_pkg::make_status(jsu_pkg::ST_SHORT_U);
                end else begin
                    first_next = unit_hi;
                    bad_next   = bad_reg | dval[4];
                    count_next = count_reg + 2'd1;
                    if (count_reg == 2'd3) begin
                        if (bad_reg || dval[4]) begin
                            emit      = 1'b1;
                            mode_next = M_TEXT;
                            burst     = jsu_pkg::make_status(jsu_pkg::ST_BAD_HEX);
                        end else if (unit_hi inside {[16'hD800:16'hDBFF]}) begin
                            mode_next = M_LO_BSL;
                        end else begin
                            emit      = 1'b1;
                            mode_next = M_TEXT;
                            burst     = jsu_pkg::utf8_encode({5'b0, unit_hi});
                        end
                    end
                end
            end
            M_LO_BSL: begin
                if (source_end || byte_in != 8'h5C) begin
                    emit      = 1'b1;
                    mode_next = M_TEXT;
                    burst     = jsu_pkg::make_status(jsu_pkg::ST_NO_LOW);
                end else begin
                    mode_next = M_LO_U;
                end
            end
            M_LO_U: begin
                if (source_end || byte_in != 8'h75) begin
                    emit      = 1'b1;
                    mode_next = M_TEXT;
                    burst     = jsu_pkg::make_status(jsu_pkg::ST_NO_LOW);
                end else begin
                    mode_next   = M_HEX_LO;
                    second_next = '0;
                    count_next  = '0;
                    bad_next    = 1'b0;
                end
            end
            M_HEX_LO: begin
                if (source_end) begin
                    emit      = 1'b1;
                    mode_next = M_TEXT;
                    burst     = jsu_pkg::make_status(jsu_pkg::ST_NO_LOW);
                end else begin
                    second_next = unit_lo;
                    bad_next    = bad_reg | dval[4];
                    count_next  = count_reg + 2'd1;
                    if (count_reg == 2'd3) begin
                        emit      = 1'b1;
                        mode_next = M_TEXT;
                        if (bad_reg || dval[4]) begin
                            burst = jsu_pkg::make_status(jsu_pkg::ST_BAD_HEX_LO);
                        end else if (!(unit_lo inside {[16'hDC00:16'hDFFF]})) begin
                            burst = jsu_pkg::make_status(jsu_pkg::ST_BAD_LOW);
                        end else begin
                            burst = jsu_pkg::utf8_encode(21'h10000
                                + {1'b0, first_reg[9:0], unit_lo[9:0]});
                        end
                    end
                end
            end
            default: begin
                emit      = 1'b1;
                mode_next = M_TEXT;
                if (source_end) begin
                    burst = jsu_pkg::make_status(jsu_pkg::ST_UNTERM);
                end else if (byte_in == 8'h22) begin
                    burst = jsu_pkg::make_status(jsu_pkg::ST_CLOSED);
                end else if (byte_in == 8'h5C) begin
                    emit      = 1'b0;
                    mode_next = M_ESC;
                end else if (byte_in < 8'h20) begin
                    burst = jsu_pkg::make_status(jsu_pkg::ST_CTRL);
                end else begin
                    burst = jsu_pkg::make_byte(byte_in);
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= M_TEXT;
            first_reg  <= '0;
            second_reg <= '0;
            count_reg  <= '0;
            bad_reg    <= 1'b0;
        end else if (accept) begin
            mode_reg   <= mode_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            count_reg  <= count_next;
            bad_reg    <= bad_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/jsu_serialize.sv -----
// ----------------------------------------------------------------------------
// jsu_serialize
// Result register: holds one group of up to four result beats and sends
// them one per cycle while m_tready is high, flagging the group's last beat.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_serialize (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            load,
    input  wire jsu_pkg::burst_t burst,
    output logic                 free,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output logic [7:0]           m_tdata,
    output logic [3:0]           m_tuser,
    output logic                 m_tlast
);

    jsu_pkg::burst_t burst_reg;
    logic            valid_reg;
    logic [1:0]      idx_reg;

    assign m_tvalid = valid_reg;
    assign m_tdata  = burst_reg.data[idx_reg];
    assign m_tuser  = burst_reg.status;
    assign m_tlast  = (idx_reg == burst_reg.last_idx);
    assign free     = !valid_reg || (m_tready && m_tlast);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else if (load) begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end else if (valid_reg && m_tready) begin
            if (m_tlast) begin
                valid_reg <= 1'b0;
            end
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            burst_reg <= burst;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/json_string_unescape_utf8.sv -----
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// Decodes a JSON string body byte stream into raw UTF-8 bytes.
//
// Input beat: s_tdata[7:0] is the next body byte (after the opening quote),
// s_tuser[0] marks the end of the source text (no byte in that beat).
// Result beat: m_tdata[7:0] is a decoded byte when m_tuser is 0; otherwise
// m_tuser is a status (closed, unterminated or one of the error codes) and
// m_tdata is 0. m_tlast marks the final result of one input beat.
// Escapes emit nothing until complete; a \u escape or a surrogate pair
// emits one to four UTF-8 beats at once, other beats emit one result.
// The first result beat is registered and valid the cycle after acceptance.
// Throughput: one input beat per cycle while each gives at most one result
// and m_tready is high; a beat giving several results holds the input until
// the single result register has sent them all, one per cycle while m_tready is high.
// Reset returns to plain text state with no result pending.
// When the receiver stalls, the result beat holds and s_tready drops once
// the result register cannot take the next group.
// After closed or any error the next beat starts a new string body.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_unescape_utf8 (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] byte_in
    input  wire logic [0:0] s_tuser,   // [0] source_end
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic [3:0]      m_tuser,   // [3:0] status
    output logic            m_tlast
);

    jsu_pkg::burst_t burst;
    logic            emit;
    logic            free;
    logic            accept;

    assign s_tready = free;
    assign accept   = s_tvalid && free;

    jsu_decode u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .byte_in    (s_tdata),
        .source_end (s_tuser[0]),
        .burst      (burst),
        .emit       (emit)
    );

    jsu_serialize u_serialize (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept && emit),
        .burst    (burst),
        .free     (free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// ----- hdl/jsu_checker.sv -----
// ----------------------------------------------------------------------------
// jsu_checker
// Port-level checks for the JSON string unescaper, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_checker (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    input  wire logic       s_tready,
    input  wire logic       m_tvalid,
    input  wire logic       m_tready,
    input  wire logic [7:0] m_tdata,
    input  wire logic [3:0] m_tuser,
    input  wire logic       m_tlast
);

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled result beat changed");

    a_status_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != jsu_pkg::ST_BYTE |-> m_tlast && m_tdata == 8'h00)
        else $error("status result not a single zero beat");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser <= jsu_pkg::ST_MAX)
        else $error("status code out of range");

    a_busy_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input taken while a multi-beat group is pending");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
